### rtl/icss_pkg.sv
`default_nettype none
package icss_pkg;

  localparam int MAX_INTERVALS = 256;
  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int COORD_W = 32;
  localparam int OFS_W = 16;
  localparam int ENTRY_W = 2 * COORD_W;

  localparam logic [COORD_W-1:0] ALL_ONES = {COORD_W{1'b1}};

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic TAB_FWD = 1'b0;
  localparam logic TAB_REV = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RET_RD,
    ST_RET_CHK,
    ST_ACT_RD,
    ST_ACT_CHK,
    ST_SCAN_INIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FINISH
  } icss_state_t;

  typedef struct packed {
    logic               retire_hit;
    logic               act_hit;
    logic [COORD_W-1:0] min_nxt;
    logic [COORD_W-1:0] max_nxt;
  } icss_alu_res_t;

endpackage
`default_nettype wire

### rtl/icss_ram.sv
`default_nettype none
module icss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/icss_alu.sv
`default_nettype none
module icss_alu (
  input  wire logic [icss_pkg::ENTRY_W-1:0] entry,
  input  wire logic [icss_pkg::COORD_W-1:0] pos,
  input  wire logic [icss_pkg::OFS_W-1:0]   offset,
  input  wire logic [icss_pkg::COORD_W-1:0] cur_min,
  input  wire logic [icss_pkg::COORD_W-1:0] cur_max,
  output icss_pkg::icss_alu_res_t            res
);

  logic [icss_pkg::COORD_W-1:0] start_v;
  logic [icss_pkg::COORD_W-1:0] end_v;
  logic [icss_pkg::COORD_W-1:0] ofs_ext;
  logic [icss_pkg::COORD_W:0]   limit;
  logic [icss_pkg::COORD_W-1:0] thresh;

  assign start_v = entry[icss_pkg::COORD_W-1:0];
  assign end_v   = entry[icss_pkg::ENTRY_W-1:icss_pkg::COORD_W];
  assign ofs_ext = {{(icss_pkg::COORD_W-icss_pkg::OFS_W){1'b0}}, offset};

  always_comb begin
    limit  = {1'b0, end_v} + {1'b0, ofs_ext};
    thresh = (start_v > ofs_ext) ? (start_v - ofs_ext) : '0;
    res.retire_hit = ({1'b0, pos} >= limit);
    res.act_hit    = (pos >= thresh);
    res.min_nxt    = (start_v < cur_min) ? start_v : cur_min;
    res.max_nxt    = (end_v > cur_max) ? end_v : cur_max;
  end

endmodule
`default_nettype wire

### rtl/interval_cover_span_sweep.sv
`default_nettype none
// Sweep-line interval coverage over a forward and a reverse table of up to 256
// intervals each. A load, clear or ignored word is taken without stalling the input.
// A query word walks the forward table and then the reverse table through one shared
// compare unit and one read address shared by both RAMs. Every entry retired,
// activated or scanned in the active window is first read and then checked. Each
// table also passes through the reads that end its retire and activate loops, the
// scan setup and the scan end. A query holds the input stalled until its result is
// handed to the output register, and the hand-off waits while an earlier result is
// still held there. The word after a query is taken in the cycle after the
// hand-off, while the result waits in the output register. cover_offset may be
// written only while the block is idle.
module interval_cover_span_sweep (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [icss_pkg::OFS_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [icss_pkg::COORD_W-1:0]  in_first_coord,
  input  wire logic [icss_pkg::COORD_W-1:0]  in_second_coord,
  input  wire logic [icss_pkg::COORD_W-1:0]  in_position,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [icss_pkg::COORD_W-1:0]       out_fwd_min_start,
  output logic [icss_pkg::COORD_W-1:0]       out_fwd_max_end,
  output logic [icss_pkg::COORD_W-1:0]       out_rev_min_start,
  output logic [icss_pkg::COORD_W-1:0]       out_rev_max_end
);

  icss_pkg::icss_state_t state_r, state_nxt;

  logic [icss_pkg::OFS_W-1:0]   offset_r;
  logic [icss_pkg::COORD_W-1:0] pos_r;
  logic                         tsel_r;
  logic [icss_pkg::CNT_W-1:0]   loaded_r    [2];
  logic [icss_pkg::CNT_W-1:0]   retired_r   [2];
  logic [icss_pkg::CNT_W-1:0]   activated_r [2];
  logic [icss_pkg::CNT_W-1:0]   idx_r;
  logic [icss_pkg::COORD_W-1:0] min_r;
  logic [icss_pkg::COORD_W-1:0] max_r;
  logic [icss_pkg::COORD_W-1:0] fwd_min_r;
  logic [icss_pkg::COORD_W-1:0] fwd_max_r;
  logic [icss_pkg::COORD_W-1:0] rev_min_r;
  logic [icss_pkg::COORD_W-1:0] rev_max_r;
  logic                         out_valid_r;

  logic                         in_acc;
  logic                         fwd_dir;
  logic                         fwd_we;
  logic                         rev_we;
  logic [icss_pkg::ENTRY_W-1:0] load_word;
  logic [icss_pkg::IDX_W-1:0]   rd_addr;
  logic [icss_pkg::ENTRY_W-1:0] fwd_rdata;
  logic [icss_pkg::ENTRY_W-1:0] rev_rdata;
  logic [icss_pkg::ENTRY_W-1:0] entry;
  logic                         out_free;
  logic                         tab_empty;
  logic [icss_pkg::CNT_W-1:0]   cur_ret;
  logic [icss_pkg::CNT_W-1:0]   cur_act;
  logic [icss_pkg::CNT_W-1:0]   cur_load;
  icss_pkg::icss_alu_res_t      alu_res;

  assign in_acc   = in_valid && !in_stall;
  assign fwd_dir  = (in_first_coord < in_second_coord);
  assign out_free = !out_valid_r || !out_stall;
  assign cur_ret  = retired_r[tsel_r];
  assign cur_act  = activated_r[tsel_r];
  assign cur_load = loaded_r[tsel_r];
  assign tab_empty = (cur_ret == cur_act);
  assign entry    = (tsel_r == icss_pkg::TAB_FWD) ? fwd_rdata : rev_rdata;

  assign load_word = fwd_dir ? {in_second_coord, in_first_coord}
                             : {in_first_coord, in_second_coord};
  assign fwd_we = in_acc && (in_kind == icss_pkg::KIND_LOAD) && fwd_dir &&
                  (loaded_r[0] != icss_pkg::CNT_W'(icss_pkg::MAX_INTERVALS));
  assign rev_we = in_acc && (in_kind == icss_pkg::KIND_LOAD) && !fwd_dir &&
                  (loaded_r[1] != icss_pkg::CNT_W'(icss_pkg::MAX_INTERVALS));

  icss_ram #(.WIDTH(icss_pkg::ENTRY_W), .DEPTH(icss_pkg::MAX_INTERVALS)) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (loaded_r[0][icss_pkg::IDX_W-1:0]),
    .wdata (load_word),
    .raddr (rd_addr),
    .rdata (fwd_rdata)
  );

  icss_ram #(.WIDTH(icss_pkg::ENTRY_W), .DEPTH(icss_pkg::MAX_INTERVALS)) u_rev_ram (
    .clk   (clk),
    .we    (rev_we),
    .waddr (loaded_r[1][icss_pkg::IDX_W-1:0]),
    .wdata (load_word),
    .raddr (rd_addr),
    .rdata (rev_rdata)
  );

  icss_alu u_alu (
    .entry   (entry),
    .pos     (pos_r),
    .offset  (offset_r),
    .cur_min (min_r),
    .cur_max (max_r),
    .res     (alu_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      icss_pkg::ST_IDLE: begin
        if (in_valid && in_kind == icss_pkg::KIND_QUERY) begin
          state_nxt = icss_pkg::ST_RET_RD;
        end
      end
      icss_pkg::ST_RET_RD: begin
        state_nxt = (cur_ret < cur_act) ? icss_pkg::ST_RET_CHK : icss_pkg::ST_ACT_RD;
      end
      icss_pkg::ST_RET_CHK: begin
        state_nxt = alu_res.retire_hit ? icss_pkg::ST_RET_RD : icss_pkg::ST_ACT_RD;
      end
      icss_pkg::ST_ACT_RD: begin
        state_nxt = (cur_act < cur_load) ? icss_pkg::ST_ACT_CHK : icss_pkg::ST_SCAN_INIT;
      end
      icss_pkg::ST_ACT_CHK: begin
        state_nxt = alu_res.act_hit ? icss_pkg::ST_ACT_RD : icss_pkg::ST_SCAN_INIT;
      end
      icss_pkg::ST_SCAN_INIT: begin
        state_nxt = icss_pkg::ST_SCAN_RD;
      end
      icss_pkg::ST_SCAN_RD: begin
        if (idx_r < cur_act) begin
          state_nxt = icss_pkg::ST_SCAN_CHK;
        end else if (tsel_r == icss_pkg::TAB_FWD) begin
          state_nxt = icss_pkg::ST_RET_RD;
        end else begin
          state_nxt = icss_pkg::ST_FINISH;
        end
      end
      icss_pkg::ST_SCAN_CHK: begin
        state_nxt = icss_pkg::ST_SCAN_RD;
      end
      icss_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = icss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = icss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_addr  = idx_r[icss_pkg::IDX_W-1:0];
    case (state_r)
      icss_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      icss_pkg::ST_RET_RD: begin
        rd_addr = cur_ret[icss_pkg::IDX_W-1:0];
      end
      icss_pkg::ST_ACT_RD: begin
        rd_addr = cur_act[icss_pkg::IDX_W-1:0];
      end
      default: begin
        rd_addr = idx_r[icss_pkg::IDX_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= icss_pkg::ST_IDLE;
      offset_r       <= '0;
      tsel_r         <= icss_pkg::TAB_FWD;
      out_valid_r    <= 1'b0;
      loaded_r[0]    <= '0;
      loaded_r[1]    <= '0;
      retired_r[0]   <= '0;
      retired_r[1]   <= '0;
      activated_r[0] <= '0;
      activated_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      if (state_r == icss_pkg::ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        icss_pkg::ST_IDLE: begin
          if (in_acc) begin
            case (in_kind)
              icss_pkg::KIND_LOAD: begin
                if (fwd_we) begin
                  loaded_r[0] <= loaded_r[0] + 1'b1;
                end
                if (rev_we) begin
                  loaded_r[1] <= loaded_r[1] + 1'b1;
                end
              end
              icss_pkg::KIND_CLEAR: begin
                loaded_r[0]    <= '0;
                loaded_r[1]    <= '0;
                retired_r[0]   <= '0;
                retired_r[1]   <= '0;
                activated_r[0] <= '0;
                activated_r[1] <= '0;
              end
              icss_pkg::KIND_QUERY: begin
                tsel_r <= icss_pkg::TAB_FWD;
              end
              default: begin
              end
            endcase
          end
        end
        icss_pkg::ST_RET_CHK: begin
          if (alu_res.retire_hit) begin
            retired_r[tsel_r] <= cur_ret + 1'b1;
          end
        end
        icss_pkg::ST_ACT_CHK: begin
          if (alu_res.act_hit) begin
            activated_r[tsel_r] <= cur_act + 1'b1;
          end
        end
        icss_pkg::ST_SCAN_RD: begin
          if (!(idx_r < cur_act) && tsel_r == icss_pkg::TAB_FWD) begin
            tsel_r <= icss_pkg::TAB_REV;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      icss_pkg::ST_IDLE: begin
        if (in_acc) begin
          pos_r <= in_position;
        end
      end
      icss_pkg::ST_SCAN_INIT: begin
        idx_r <= cur_ret;
        min_r <= icss_pkg::ALL_ONES;
        max_r <= '0;
      end
      icss_pkg::ST_SCAN_RD: begin
        if (!(idx_r < cur_act)) begin
          if (tsel_r == icss_pkg::TAB_FWD) begin
            fwd_min_r <= tab_empty ? icss_pkg::ALL_ONES : min_r;
            fwd_max_r <= tab_empty ? icss_pkg::ALL_ONES : max_r;
          end else begin
            rev_min_r <= tab_empty ? icss_pkg::ALL_ONES : min_r;
            rev_max_r <= tab_empty ? icss_pkg::ALL_ONES : max_r;
          end
        end
      end
      icss_pkg::ST_SCAN_CHK: begin
        min_r <= alu_res.min_nxt;
        max_r <= alu_res.max_nxt;
        idx_r <= idx_r + 1'b1;
      end
      icss_pkg::ST_FINISH: begin
        if (out_free) begin
          out_fwd_min_start <= fwd_min_r;
          out_fwd_max_end   <= fwd_max_r;
          out_rev_min_start <= rev_min_r;
          out_rev_max_end   <= rev_max_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
  import icss_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam logic [COORD_W-1:0] MAX_COORD = 32'hFFFF_FFFE;
  localparam int RANDOM_WORDS = 1550;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DIR_ROWS = 23;
  localparam int SPAN_SLOTS = 1024;

  typedef struct packed {
    logic [COORD_W-1:0] fwd_min_start;
    logic [COORD_W-1:0] fwd_max_end;
    logic [COORD_W-1:0] rev_min_start;
    logic [COORD_W-1:0] rev_max_end;
  } span_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] first_coord;
    logic [COORD_W-1:0] second_coord;
    logic [COORD_W-1:0] position;
    logic               typed;
    span_t              span;
  } stim_row_t;

  localparam span_t NO_SPAN = '0;
  localparam span_t EMPTY_SPAN = {ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [OFS_W-1:0]   cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = KIND_NOP;
  logic [COORD_W-1:0] in_first_coord = '0;
  logic [COORD_W-1:0] in_second_coord = '0;
  logic [COORD_W-1:0] in_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COORD_W-1:0] out_fwd_min_start;
  logic [COORD_W-1:0] out_fwd_max_end;
  logic [COORD_W-1:0] out_rev_min_start;
  logic [COORD_W-1:0] out_rev_max_end;

  logic [COORD_W-1:0] ivl_start [2][MAX_INTERVALS];
  logic [COORD_W-1:0] ivl_end [2][MAX_INTERVALS];
  int unsigned        n_loaded [2] = '{0, 0};
  int unsigned        n_retired [2] = '{0, 0};
  int unsigned        n_admitted [2] = '{0, 0};
  logic [OFS_W-1:0]   cover_ofs = '0;
  span_t              span_fifo [SPAN_SLOTS];
  int                 span_wr = 0;
  int                 span_rd = 0;

  bit    calm = 1'b0;
  bit    typed_on = 1'b0;
  span_t typed_span = '0;
  int    mismatches = 0;
  int    results_seen = 0;
  int    quiet_cycles = 0;
  int    hold_left = 0;
  int    next_hold = 60;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_QUERY, 32'd0, 32'd0, 32'd0, 1'b1, EMPTY_SPAN},
    '{KIND_NOP, MAX_COORD, MAX_COORD, MAX_COORD, 1'b0, NO_SPAN},
    '{KIND_LOAD, 32'd0, MAX_COORD, 32'd0, 1'b0, NO_SPAN},
    '{KIND_LOAD, MAX_COORD, 32'd0, 32'd0, 1'b0, NO_SPAN},
    '{KIND_LOAD, 32'd5, 32'd5, 32'd0, 1'b0, NO_SPAN},
    '{KIND_QUERY, 32'd0, 32'd0, 32'd0, 1'b1, {32'd0, MAX_COORD, 32'd0, MAX_COORD}},
    '{KIND_QUERY, 32'd0, 32'd0, 32'd3, 1'b0, NO_SPAN},
    '{KIND_QUERY, 32'd0, 32'd0, 32'd0, 1'b0, NO_SPAN},
    '{KIND_QUERY, 32'd0, 32'd0, MAX_COORD, 1'b0, NO_SPAN},
    '{KIND_CLEAR, 32'd0, 32'd0, 32'd0, 1'b0, NO_SPAN},
    '{KIND_QUERY, 32'd0, 32'd0, MAX_COORD, 1'b1, EMPTY_SPAN},
    '{KIND_LOAD, 32'd10, 32'd100, 32'd0, 1'b0, NO_SPAN},
    '{KIND_LOAD, 32'd12, 32'd14, 32'd0, 1'b0, NO_SPAN},
    '{KIND_LOAD, 32'd2, 32'd30, 32'd0, 1'b0, NO_SPAN},
    '{KIND_LOAD, 32'd40, 32'd8, 32'd0, 1'b0, NO_SPAN},
    '{KIND_QUERY, 32'd0, 32'd0, 32'd13, 1'b0, NO_SPAN},
    '{KIND_QUERY, 32'd0, 32'd0, 32'd50, 1'b0, NO_SPAN},
    '{KIND_QUERY, 32'd0, 32'd0, 32'd100, 1'b0, NO_SPAN},
    '{KIND_CLEAR, MAX_COORD, MAX_COORD, MAX_COORD, 1'b0, NO_SPAN},
    '{KIND_LOAD, MAX_COORD - 32'd1, MAX_COORD, 32'd0, 1'b0, NO_SPAN},
    '{KIND_QUERY, 32'd0, 32'd0, MAX_COORD, 1'b0, NO_SPAN},
    '{KIND_QUERY, 32'd0, 32'd0, MAX_COORD, 1'b0, NO_SPAN},
    '{KIND_NOP, 32'd0, 32'd0, 32'd0, 1'b0, NO_SPAN}
  };

  interval_cover_span_sweep u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_first_coord    (in_first_coord),
    .in_second_coord   (in_second_coord),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fwd_min_start (out_fwd_min_start),
    .out_fwd_max_end   (out_fwd_max_end),
    .out_rev_min_start (out_rev_min_start),
    .out_rev_max_end   (out_rev_max_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [COORD_W-1:0] clamp_coord(input longint unsigned v);
    return (v > MAX_COORD) ? MAX_COORD : v[COORD_W-1:0];
  endfunction

  function automatic void span_put(input span_t v);
    span_fifo[span_wr % SPAN_SLOTS] = v;
    span_wr++;
  endfunction

  function automatic span_t span_take();
    span_t v;
    v = span_fifo[span_rd % SPAN_SLOTS];
    span_rd++;
    return v;
  endfunction

  function automatic void file_interval(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    int t;
    t = (a < b) ? TAB_FWD : TAB_REV;
    if (n_loaded[t] < MAX_INTERVALS) begin
      if (a < b) begin
        ivl_start[t][n_loaded[t]] = a;
        ivl_end[t][n_loaded[t]] = b;
      end else begin
        ivl_start[t][n_loaded[t]] = b;
        ivl_end[t][n_loaded[t]] = a;
      end
      n_loaded[t]++;
    end
  endfunction

  function automatic void sweep_table(input int t, input logic [COORD_W-1:0] pos,
                                      output logic [COORD_W-1:0] lo,
                                      output logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] s;
    lo = ALL_ONES;
    hi = ALL_ONES;
    while (n_retired[t] < n_admitted[t] &&
           {1'b0, pos} >= {1'b0, ivl_end[t][n_retired[t]]} + {17'd0, cover_ofs})
      n_retired[t]++;
    while (n_admitted[t] < n_loaded[t]) begin
      s = ivl_start[t][n_admitted[t]];
      s = (s > cover_ofs) ? s - cover_ofs : '0;
      if (pos < s) break;
      n_admitted[t]++;
    end
    for (int i = n_retired[t]; i < n_admitted[t]; i++) begin
      if (i == n_retired[t] || ivl_start[t][i] < lo) lo = ivl_start[t][i];
      if (i == n_retired[t] || ivl_end[t][i] > hi) hi = ivl_end[t][i];
    end
  endfunction

  function automatic span_t predict_span(input logic [COORD_W-1:0] pos);
    span_t r;
    sweep_table(TAB_FWD, pos, r.fwd_min_start, r.fwd_max_end);
    sweep_table(TAB_REV, pos, r.rev_min_start, r.rev_max_end);
    return r;
  endfunction

  task automatic send_word(input logic [1:0] k, input logic [COORD_W-1:0] a,
                           input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] p);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_first_coord <= a;
    in_second_coord <= b;
    in_position <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (span_wr != span_rd) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_cover_ofs(input logic [OFS_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cover_ofs = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      case (in_kind)
        KIND_LOAD: file_interval(in_first_coord, in_second_coord);
        KIND_QUERY: begin
          if (typed_on) begin
            void'(predict_span(in_position));
            span_put(typed_span);
          end else begin
            span_put(predict_span(in_position));
          end
        end
        KIND_CLEAR: begin
          n_loaded = '{0, 0};
          n_retired = '{0, 0};
          n_admitted = '{0, 0};
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    span_t got;
    span_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_fwd_min_start, out_fwd_max_end, out_rev_min_start, out_rev_max_end};
      results_seen++;
      if (span_wr == span_rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: fwd %h/%h rev %h/%h",
                   got.fwd_min_start, got.fwd_max_end, got.rev_min_start, got.rev_max_end);
      end else begin
        want = span_take();
        if (got.fwd_min_start !== want.fwd_min_start || got.fwd_max_end !== want.fwd_max_end ||
            got.rev_min_start !== want.rev_min_start || got.rev_max_end !== want.rev_max_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: fwd %h/%h rev %h/%h, expected fwd %h/%h rev %h/%h",
                     results_seen, got.fwd_min_start, got.fwd_max_end, got.rev_min_start,
                     got.rev_max_end, want.fwd_min_start, want.fwd_max_end,
                     want.rev_min_start, want.rev_max_end);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (results_seen >= next_hold) begin
      hold_left = HOLD_CYCLES;
      next_hold += 540;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 28);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("interval_cover_span_sweep regression: fail");
      $finish;
    end
  end

  initial begin
    int                 sent;
    int                 phase;
    int                 phase_end;
    int                 burst;
    int                 mode;
    int                 pick;
    int unsigned        scale;
    logic [COORD_W-1:0] base;
    logic [COORD_W-1:0] cur_pos;
    logic [COORD_W-1:0] next_fwd;
    logic [COORD_W-1:0] next_rev;
    logic [COORD_W-1:0] lead;
    logic [COORD_W-1:0] s;
    logic [COORD_W-1:0] e;
    logic [OFS_W-1:0]   ofs;
    sent = 0;
    phase = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_on = dir_rows[i].typed;
      typed_span = dir_rows[i].span;
      send_word(dir_rows[i].kind, dir_rows[i].first_coord, dir_rows[i].second_coord,
                dir_rows[i].position);
    end
    typed_on = 1'b0;

    while (sent < RANDOM_WORDS) begin
      settle(8);
      case (phase % 6)
        0: ofs = 16'hFFFF;
        1: ofs = 16'd1;
        2: ofs = OFS_W'($urandom_range(2, 65534));
        3: ofs = 16'd0;
        4: ofs = OFS_W'($urandom_range(0, 64));
        default: ofs = OFS_W'($urandom_range(0, 65535));
      endcase
      write_cover_ofs(ofs);
      calm = (phase == 3);
      phase_end = sent + 250;

      if (phase == 2) begin
        send_word(KIND_CLEAR, $urandom, $urandom, $urandom);
        s = '0;
        for (int i = 0; i < MAX_INTERVALS + 2; i++) begin
          s = s + $urandom_range(0, 3);
          send_word(KIND_LOAD, s, s + 1 + $urandom_range(0, 400), $urandom);
        end
        s = '0;
        for (int i = 0; i < MAX_INTERVALS + 2; i++) begin
          s = s + $urandom_range(0, 3);
          send_word(KIND_LOAD, s + $urandom_range(0, 400), s, $urandom);
        end
        send_word(KIND_QUERY, $urandom, $urandom, 32'd2000);
        send_word(KIND_QUERY, $urandom, $urandom, MAX_COORD);
        sent += 2 * MAX_INTERVALS + 7;
      end

      while (sent < phase_end && sent < RANDOM_WORDS) begin
        mode = $urandom_range(0, 2);
        case (mode)
          0: begin
            base = '0;
            scale = 24;
          end
          1: begin
            base = MAX_COORD - 32'd3000;
            scale = 24;
          end
          default: begin
            base = $urandom;
            scale = 1 << 20;
          end
        endcase
        cur_pos = base;
        next_fwd = base;
        next_rev = base;
        send_word(KIND_CLEAR, $urandom, $urandom, $urandom);
        sent++;
        burst = $urandom_range(20, 80);
        repeat (burst) begin
          pick = $urandom_range(0, 99);
          if (pick < 20) begin
            lead = (next_fwd > cur_pos) ? next_fwd : cur_pos;
            s = clamp_coord(64'(lead) + $urandom_range(0, scale));
            e = clamp_coord(64'(s) + 1 + $urandom_range(0, 4 * scale));
            if (s >= e) s = e - 1;
            next_fwd = s;
            send_word(KIND_LOAD, s, e, $urandom);
          end else if (pick < 40) begin
            lead = (next_rev > cur_pos) ? next_rev : cur_pos;
            s = clamp_coord(64'(lead) + $urandom_range(0, scale));
            e = clamp_coord(64'(s) + $urandom_range(0, 4 * scale));
            next_rev = s;
            send_word(KIND_LOAD, e, s, $urandom);
          end else if (pick < 85) begin
            cur_pos = clamp_coord(64'(cur_pos) + $urandom_range(0, scale));
            send_word(KIND_QUERY, $urandom, $urandom, cur_pos);
          end else begin
            case ($urandom_range(0, 4))
              0: send_word(KIND_NOP, $urandom, $urandom, $urandom);
              1: send_word(KIND_LOAD, clamp_coord($urandom), clamp_coord($urandom), $urandom);
              2: send_word(KIND_QUERY, $urandom, $urandom, $urandom_range(0, cur_pos));
              3: begin
                cur_pos = MAX_COORD;
                send_word(KIND_QUERY, $urandom, $urandom, cur_pos);
              end
              default: begin
                cur_pos = base;
                next_fwd = base;
                next_rev = base;
                send_word(KIND_CLEAR, $urandom, $urandom, $urandom);
              end
            endcase
          end
          sent++;
        end
      end
      phase++;
    end

    calm = 1'b0;
    settle(64);
    if (mismatches == 0) begin
      $display("interval_cover_span_sweep regression: pass");
    end else begin
      $display("interval_cover_span_sweep regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/icss_pkg.sv
rtl/icss_ram.sv
rtl/icss_alu.sv
rtl/interval_cover_span_sweep.sv
tb/tb_top.sv
